[rtl/core/tfn_pkg.sv]
// Shared constants for the triangle face normal core.
// Used by the front end, the queue sizing in the top level and the back end.
package tfn_pkg;

   localparam int unsigned COORD_WIDTH_DEFAULT = 16;
   localparam int unsigned FRAC_BITS           = 14;
   localparam int unsigned ROOT_BITS           = FRAC_BITS + 2;
   localparam int unsigned NORM_WIDTH          = 16;
   localparam int unsigned QUEUE_DEPTH         = 6;

endpackage

[rtl/core/tfn_front.sv]
// Front end: edge vectors and exact cross product, three register stages.
// Depends on tfn_pkg for the default coordinate width.
module tfn_front #(
   parameter int unsigned COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [COORD_WIDTH-1:0]  a_x,
   input  logic signed [COORD_WIDTH-1:0]  a_y,
   input  logic signed [COORD_WIDTH-1:0]  a_z,
   input  logic signed [COORD_WIDTH-1:0]  b_x,
   input  logic signed [COORD_WIDTH-1:0]  b_y,
   input  logic signed [COORD_WIDTH-1:0]  b_z,
   input  logic signed [COORD_WIDTH-1:0]  c_x,
   input  logic signed [COORD_WIDTH-1:0]  c_y,
   input  logic signed [COORD_WIDTH-1:0]  c_z,
   output logic                           out_valid,
   output logic [3*(2*(COORD_WIDTH+1)+1)-1:0] out_cross
);
   import tfn_pkg::*;

   localparam int unsigned EW = COORD_WIDTH + 1;
   localparam int unsigned PW = 2 * EW;
   localparam int unsigned NW = PW + 1;

   logic [2:0] vld_ff;

   logic signed [EW-1:0] e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic signed [EW-1:0] e1x_in, e1y_in, e1z_in, e2x_in, e2y_in, e2z_in;
   logic signed [PW-1:0] prd_ff [0:5];
   logic signed [NW-1:0] crs_ff [0:2];
   logic signed [NW-1:0] crs_in [0:2];

   assign e1x_in = {b_x[COORD_WIDTH-1], b_x} - {a_x[COORD_WIDTH-1], a_x};
   assign e1y_in = {b_y[COORD_WIDTH-1], b_y} - {a_y[COORD_WIDTH-1], a_y};
   assign e1z_in = {b_z[COORD_WIDTH-1], b_z} - {a_z[COORD_WIDTH-1], a_z};
   assign e2x_in = {c_x[COORD_WIDTH-1], c_x} - {a_x[COORD_WIDTH-1], a_x};
   assign e2y_in = {c_y[COORD_WIDTH-1], c_y} - {a_y[COORD_WIDTH-1], a_y};
   assign e2z_in = {c_z[COORD_WIDTH-1], c_z} - {a_z[COORD_WIDTH-1], a_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         crs_in[i] = {prd_ff[2*i][PW-1], prd_ff[2*i]}
                   - {prd_ff[2*i+1][PW-1], prd_ff[2*i+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      e1x_ff    <= e1x_in;
      e1y_ff    <= e1y_in;
      e1z_ff    <= e1z_in;
      e2x_ff    <= e2x_in;
      e2y_ff    <= e2y_in;
      e2z_ff    <= e2z_in;
      prd_ff[0] <= e1y_ff * e2z_ff;
      prd_ff[1] <= e1z_ff * e2y_ff;
      prd_ff[2] <= e1z_ff * e2x_ff;
      prd_ff[3] <= e1x_ff * e2z_ff;
      prd_ff[4] <= e1x_ff * e2y_ff;
      prd_ff[5] <= e1y_ff * e2x_ff;
      crs_ff    <= crs_in;
   end

   assign out_valid = vld_ff[2];
   assign out_cross = {crs_ff[2], crs_ff[1], crs_ff[0]};

endmodule

[rtl/core/tfn_queue.sv]
// Short first-in first-out queue between the front and back ends.
// Register array storage; no package dependency beyond the default depth.
module tfn_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = tfn_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int unsigned PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PTW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNW-1:0]   count_ff;

   function automatic logic [PTW-1:0] next_ptr(input logic [PTW-1:0] p);
      return (p == PTW'(DEPTH - 1)) ? '0 : p + PTW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CNW'(1);
            2'b01:   count_ff <= count_ff - CNW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

endmodule

[rtl/core/tfn_back.sv]
// Back end: magnitudes, squares, length sum, bit-per-stage ratio root and rounding.
// Depends on tfn_pkg for fraction bits, root stage count and result width.
module tfn_back #(
   parameter int unsigned COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [3*(2*(COORD_WIDTH+1)+1)-1:0]    in_cross,
   output logic                                  in_pop,
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output logic signed [tfn_pkg::NORM_WIDTH-1:0] norm_x,
   output logic signed [tfn_pkg::NORM_WIDTH-1:0] norm_y,
   output logic signed [tfn_pkg::NORM_WIDTH-1:0] norm_z,
   output logic                                  degenerate
);
   import tfn_pkg::*;

   localparam int unsigned EW  = COORD_WIDTH + 1;
   localparam int unsigned MW  = 2 * EW;
   localparam int unsigned NW  = MW + 1;
   localparam int unsigned QW  = 2 * MW;
   localparam int unsigned SW  = QW + 2;
   localparam int unsigned FW  = SW + ROOT_BITS;
   localparam int unsigned XW  = SW + 2 * ROOT_BITS + 1;
   localparam int unsigned LAT = ROOT_BITS + 4;
   localparam int unsigned MSH = 2 * (FRAC_BITS + 1);

   logic adv;
   logic [LAT-1:0] vld_ff;

   logic [MW-1:0]        mag_ff [0:2];
   logic [MW-1:0]        mag_in [0:2];
   logic [2:0]           neg0_ff, neg1_ff;
   logic [QW-1:0]        sq_ff  [0:2];

   logic [XW-1:0]        rem_ff [0:2][0:ROOT_BITS];
   logic [XW-1:0]        rem_in [0:2][0:ROOT_BITS];
   logic [FW-1:0]        fs_ff  [0:2][0:ROOT_BITS];
   logic [FW-1:0]        fs_in  [0:2][0:ROOT_BITS];
   logic [ROOT_BITS-1:0] f_ff   [0:2][0:ROOT_BITS];
   logic [ROOT_BITS-1:0] f_in   [0:2][0:ROOT_BITS];
   logic [SW-1:0]        s_ff   [0:ROOT_BITS];
   logic [SW-1:0]        s_in   [0:ROOT_BITS];
   logic [2:0]           neg_ff [0:ROOT_BITS];
   logic [2:0]           neg_in [0:ROOT_BITS];
   logic                 dg_ff  [0:ROOT_BITS];
   logic                 dg_in  [0:ROOT_BITS];

   logic [NORM_WIDTH-1:0] nrm_ff [0:2];
   logic [NORM_WIDTH-1:0] nrm_in [0:2];
   logic                  deg_ff;

   // the whole back pipe moves together; hold everything while the result waits
   assign adv    = !vld_ff[LAT-1] || !out_stall;
   assign in_pop = in_valid && adv;

   always_comb begin
      logic [NW-1:0] c;
      logic [NW-1:0] cn;
      for (int i = 0; i < 3; i++) begin
         c         = in_cross[i*NW +: NW];
         cn        = -c;
         mag_in[i] = c[NW-1] ? cn[MW-1:0] : c[MW-1:0];
      end
   end

   always_comb begin
      logic [XW-1:0] trial;
      s_in[0]  = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      dg_in[0] = (s_in[0] == '0);
      neg_in[0] = neg1_ff;
      for (int c = 0; c < 3; c++) begin
         rem_in[c][0] = XW'(sq_ff[c]) << MSH;
         fs_in[c][0]  = '0;
         f_in[c][0]   = '0;
      end
      // one result bit per stage, most significant first
      for (int g = 0; g < ROOT_BITS; g++) begin
         s_in[g+1]   = s_ff[g];
         neg_in[g+1] = neg_ff[g];
         dg_in[g+1]  = dg_ff[g];
         for (int c = 0; c < 3; c++) begin
            trial = (XW'(fs_ff[c][g]) << (ROOT_BITS - g))
                  + (XW'(s_ff[g]) << (2 * (ROOT_BITS - 1 - g)));
            if (rem_ff[c][g] >= trial) begin
               rem_in[c][g+1] = rem_ff[c][g] - trial;
               fs_in[c][g+1]  = fs_ff[c][g] + (FW'(s_ff[g]) << (ROOT_BITS - 1 - g));
               f_in[c][g+1]   = f_ff[c][g] | (ROOT_BITS'(1) << (ROOT_BITS - 1 - g));
            end else begin
               rem_in[c][g+1] = rem_ff[c][g];
               fs_in[c][g+1]  = fs_ff[c][g];
               f_in[c][g+1]   = f_ff[c][g];
            end
         end
      end
   end

   always_comb begin
      logic [ROOT_BITS:0]    k;
      logic [NORM_WIDTH-1:0] kv;
      for (int c = 0; c < 3; c++) begin
         k  = ({1'b0, f_ff[c][ROOT_BITS]} + (ROOT_BITS + 1)'(1)) >> 1;
         kv = NORM_WIDTH'(k);
         if (dg_ff[ROOT_BITS]) begin
            nrm_in[c] = '0;
         end else if (neg_ff[ROOT_BITS][c]) begin
            nrm_in[c] = -kv;
         end else begin
            nrm_in[c] = kv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]  <= mag_in[i];
            neg0_ff[i] <= in_cross[i*NW + NW - 1];
            sq_ff[i]   <= mag_ff[i] * mag_ff[i];
         end
         neg1_ff <= neg0_ff;
         rem_ff  <= rem_in;
         fs_ff   <= fs_in;
         f_ff    <= f_in;
         s_ff    <= s_in;
         neg_ff  <= neg_in;
         dg_ff   <= dg_in;
         nrm_ff  <= nrm_in;
         deg_ff  <= dg_ff[ROOT_BITS];
      end
   end

   assign out_valid  = vld_ff[LAT-1];
   assign norm_x     = nrm_ff[0];
   assign norm_y     = nrm_ff[1];
   assign norm_z     = nrm_ff[2];
   assign degenerate = deg_ff;

endmodule

[rtl/core/triangle_face_normal_core.sv]
// Triangle face normal core: top level joining front end, queue and back end.
// Depends on tfn_pkg, tfn_front, tfn_queue and tfn_back.
//
//   channel   ports                        direction   moves per transfer
//   req       req_valid/req_stall, req_*   in          three corners, Q2.14
//   rsp       rsp_valid/rsp_stall, rsp_*   out         unit normal and flag
//
// One triangle per cycle sustained while rsp_stall stays low; the path runs
// through three front stages, the queue and twenty back stages (sixteen of
// them the one-bit-per-stage root of the normalising ratio).
// Synchronous reset clears all valid state; payload registers are not reset.
// rsp_stall freezes the back pipe only; the front keeps draining into the queue
// and req_stall rises once six triangles are between acceptance and the back pipe.
module triangle_face_normal_core #(
   parameter int unsigned COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_WIDTH-1:0]         req_a_x,
   input  logic signed [COORD_WIDTH-1:0]         req_a_y,
   input  logic signed [COORD_WIDTH-1:0]         req_a_z,
   input  logic signed [COORD_WIDTH-1:0]         req_b_x,
   input  logic signed [COORD_WIDTH-1:0]         req_b_y,
   input  logic signed [COORD_WIDTH-1:0]         req_b_z,
   input  logic signed [COORD_WIDTH-1:0]         req_c_x,
   input  logic signed [COORD_WIDTH-1:0]         req_c_y,
   input  logic signed [COORD_WIDTH-1:0]         req_c_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [tfn_pkg::NORM_WIDTH-1:0] rsp_norm_x,
   output logic signed [tfn_pkg::NORM_WIDTH-1:0] rsp_norm_y,
   output logic signed [tfn_pkg::NORM_WIDTH-1:0] rsp_norm_z,
   output logic                                  rsp_degenerate
);
   import tfn_pkg::*;

   localparam int unsigned XBW = 3 * (2 * (COORD_WIDTH + 1) + 1);
   localparam int unsigned OCW = $clog2(QUEUE_DEPTH + 1);

   logic           accept;
   logic           front_valid;
   logic [XBW-1:0] front_cross;
   logic           q_valid;
   logic [XBW-1:0] q_data;
   logic           q_pop;
   logic [OCW-1:0] occ_ff;
   logic [OCW-1:0] occ_in;

   // count triangles accepted and not yet taken by the back pipe
   assign accept    = req_valid && !req_stall;
   assign req_stall = (occ_ff == OCW'(QUEUE_DEPTH));

   always_comb begin
      occ_in = occ_ff;
      case ({accept, q_pop})
         2'b10:   occ_in = occ_ff + OCW'(1);
         2'b01:   occ_in = occ_ff - OCW'(1);
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   tfn_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .a_x       (req_a_x),
      .a_y       (req_a_y),
      .a_z       (req_a_z),
      .b_x       (req_b_x),
      .b_y       (req_b_y),
      .b_z       (req_b_z),
      .c_x       (req_c_x),
      .c_y       (req_c_y),
      .c_z       (req_c_z),
      .out_valid (front_valid),
      .out_cross (front_cross)
   );

   tfn_queue #(
      .WIDTH (XBW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_data  (front_cross),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   tfn_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_cross   (q_data),
      .in_pop     (q_pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .norm_x     (rsp_norm_x),
      .norm_y     (rsp_norm_y),
      .norm_z     (rsp_norm_z),
      .degenerate (rsp_degenerate)
   );

endmodule
